// ===== hdl/http_message_head_parser_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the HTTP message head parser
// Every user provides clk and arst_n in the scope of the macro.
// ---------------------------------------------------------------------------
`ifndef HTTP_MESSAGE_HEAD_PARSER_CORE_MACROS_SVH
`define HTTP_MESSAGE_HEAD_PARSER_CORE_MACROS_SVH

// Same-cycle implication.
`define HMHP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HMHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hmhp_pkg.sv =====
// ---------------------------------------------------------------------------
// hmhp_pkg
// Shared constants, result type and helper functions of the head parser.
// ---------------------------------------------------------------------------
package hmhp_pkg;

	// Parse states
	localparam int STATE_W = 5;
	localparam logic [STATE_W-1:0] S_METHOD_START  = 5'd0;
	localparam logic [STATE_W-1:0] S_METHOD        = 5'd1;
	localparam logic [STATE_W-1:0] S_SPACES_PATH   = 5'd2;
	localparam logic [STATE_W-1:0] S_PATH          = 5'd3;
	localparam logic [STATE_W-1:0] S_SPACES_VER    = 5'd4;
	localparam logic [STATE_W-1:0] S_VER_WORD      = 5'd5;
	localparam logic [STATE_W-1:0] S_MAJOR         = 5'd6;
	localparam logic [STATE_W-1:0] S_MINOR         = 5'd7;
	localparam logic [STATE_W-1:0] S_FIN_REQ       = 5'd8;
	localparam logic [STATE_W-1:0] S_SPACES_STATUS = 5'd9;
	localparam logic [STATE_W-1:0] S_STATUS        = 5'd10;
	localparam logic [STATE_W-1:0] S_SPACES_MSG    = 5'd11;
	localparam logic [STATE_W-1:0] S_MSG           = 5'd12;
	localparam logic [STATE_W-1:0] S_FIN_STATUS    = 5'd13;
	localparam logic [STATE_W-1:0] S_HDR_START     = 5'd14;
	localparam logic [STATE_W-1:0] S_HDR_NAME      = 5'd15;
	localparam logic [STATE_W-1:0] S_SPACES_VALUE  = 5'd16;
	localparam logic [STATE_W-1:0] S_HDR_VALUE     = 5'd17;
	localparam logic [STATE_W-1:0] S_HDR_END       = 5'd18;
	localparam logic [STATE_W-1:0] S_HEAD_END      = 5'd19;
	localparam logic [STATE_W-1:0] S_PAST          = 5'd20;
	localparam logic [STATE_W-1:0] S_ERROR         = 5'd21;

	// Byte roles
	localparam logic [3:0] ROLE_SPACE   = 4'd0;
	localparam logic [3:0] ROLE_METHOD  = 4'd1;
	localparam logic [3:0] ROLE_PATH    = 4'd2;
	localparam logic [3:0] ROLE_VERSION = 4'd3;
	localparam logic [3:0] ROLE_STATUS  = 4'd4;
	localparam logic [3:0] ROLE_TEXT    = 4'd5;
	localparam logic [3:0] ROLE_NAME    = 4'd6;
	localparam logic [3:0] ROLE_VALUE   = 4'd7;
	localparam logic [3:0] ROLE_DELIM   = 4'd8;
	localparam logic [3:0] ROLE_PAST    = 4'd9;

	// Events
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_REQ_DONE  = 3'd1;
	localparam logic [2:0] EV_STAT_DONE = 3'd2;
	localparam logic [2:0] EV_HDR_DONE  = 3'd3;
	localparam logic [2:0] EV_HEAD_DONE = 3'd4;
	localparam logic [2:0] EV_ERROR     = 3'd5;

	// Methods
	localparam logic METHOD_GET  = 1'b0;
	localparam logic METHOD_POST = 1'b1;

	// Word lengths
	localparam logic [2:0] LEN_GET  = 3'd3;
	localparam logic [2:0] LEN_POST = 3'd4;
	localparam logic [2:0] LEN_HTTP = 3'd4;

	// Characters
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_O     = 8'h4F;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_H     = 8'h48;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_PARSE_MODE = 1'b0;   // word index, paddr[2]

	typedef struct packed {
		logic [3:0]  byte_role;
		logic        field_start;
		logic        field_end;
		logic [2:0]  event_res;
		logic        method_kind;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [15:0] status_value;
	} result_t;

	function automatic logic [7:0] method_char(input logic meth, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		if (meth == METHOD_POST) begin
			case (pos)
				3'd0:    ch = CH_P;
				3'd1:    ch = CH_O;
				3'd2:    ch = CH_S;
				3'd3:    ch = CH_T;
				default: ch = 8'h00;
			endcase
		end else begin
			case (pos)
				3'd0:    ch = CH_G;
				3'd1:    ch = CH_E;
				3'd2:    ch = CH_T;
				default: ch = 8'h00;
			endcase
		end
		return ch;
	endfunction

	function automatic logic [7:0] http_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = CH_H;
			3'd1:    ch = CH_T;
			3'd2:    ch = CH_T;
			3'd3:    ch = CH_P;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// acc * 10 + digit, clamped to 8 bits
	function automatic logic [7:0] sat8(input logic [7:0] acc, input logic [7:0] c);
		logic [7:0]  d;
		logic [11:0] v;
		d = c - CH_ZERO;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {4'b0000, d};
		return (v > 12'd255) ? 8'hFF : v[7:0];
	endfunction

	// acc * 10 + digit, clamped to 16 bits
	function automatic logic [15:0] sat16(input logic [15:0] acc, input logic [7:0] c);
		logic [7:0]  d;
		logic [19:0] v;
		d = c - CH_ZERO;
		v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {12'h000, d};
		return (v > 20'd65535) ? 16'hFFFF : v[15:0];
	endfunction

endpackage

// ===== hdl/hmhp_in_if.sv =====
// ---------------------------------------------------------------------------
// hmhp_in_if
// Input byte channel: one raw byte of the message head per beat.
// ---------------------------------------------------------------------------
interface hmhp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_message;

	modport source (output valid, output data_byte, output new_message, input ready);
	modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

// ===== hdl/hmhp_out_if.sv =====
// ---------------------------------------------------------------------------
// hmhp_out_if
// Result channel: tag and accumulators for one parsed byte per beat.
// ---------------------------------------------------------------------------
interface hmhp_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  byte_role;
	logic        field_start;
	logic        field_end;
	logic [2:0]  event_res;
	logic        method_kind;
	logic [7:0]  version_major;
	logic [7:0]  version_minor;
	logic [15:0] status_value;

	modport source (
		output valid, input ready,
		output byte_role, output field_start, output field_end, output event_res,
		output method_kind, output version_major, output version_minor, output status_value
	);
	modport sink (
		input valid, output ready,
		input byte_role, input field_start, input field_end, input event_res,
		input method_kind, input version_major, input version_minor, input status_value
	);
endinterface

// ===== hdl/hmhp_regs.sv =====
// ---------------------------------------------------------------------------
// hmhp_regs
// APB register file: holds the parse mode register.
// ---------------------------------------------------------------------------
module hmhp_regs
	import hmhp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic                  parse_mode
);

	logic mode_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_PARSE_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (wr_en) begin
			mode_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_PARSE_MODE) begin
			prdata = {{(APB_DATA_W-1){1'b0}}, mode_q};
		end
	end

	assign parse_mode = mode_q;

endmodule

// ===== hdl/hmhp_parser.sv =====
// ---------------------------------------------------------------------------
// hmhp_parser
// Parse state, match position and accumulators, plus the one-byte step.
// ---------------------------------------------------------------------------
`include "http_message_head_parser_core_macros.svh"

module hmhp_parser
	import hmhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] data_byte,
	input  logic       new_message,
	input  logic       parse_mode,
	output result_t    res
);

	logic [STATE_W-1:0] state_q, st, st_n;
	logic [2:0]         mp_q, mp, mp_n;
	logic               meth_q, meth, meth_n;
	logic [7:0]         maj_q, maj, maj_n;
	logic [7:0]         min_q, mnr, min_n;
	logic [15:0]        stat_q, stv, stat_n;
	logic [3:0]         role;
	logic               fs, fe, err;
	logic [2:0]         ev;
	logic [2:0]         mlen;

	always_comb begin
		// restart before this byte when a new message begins
		st   = state_q;
		mp   = mp_q;
		meth = meth_q;
		maj  = maj_q;
		mnr  = min_q;
		stv  = stat_q;
		if (new_message) begin
			st   = parse_mode ? S_SPACES_VER : S_METHOD_START;
			mp   = 3'd0;
			meth = METHOD_GET;
			maj  = 8'd0;
			mnr  = 8'd0;
			stv  = 16'd0;
		end

		st_n   = st;
		mp_n   = mp;
		meth_n = meth;
		maj_n  = maj;
		min_n  = mnr;
		stat_n = stv;
		role   = ROLE_PAST;
		fs     = 1'b0;
		fe     = 1'b0;
		ev     = EV_NONE;
		err    = 1'b0;
		mlen   = (meth == METHOD_POST) ? LEN_POST : LEN_GET;

		case (st)
			S_METHOD_START: begin
				if (data_byte == CH_G || data_byte == CH_P) begin
					meth_n = (data_byte == CH_P) ? METHOD_POST : METHOD_GET;
					mp_n   = 3'd1;
					st_n   = S_METHOD;
					role   = ROLE_METHOD;
				end else begin
					err = 1'b1;
				end
			end
			S_METHOD: begin
				if (mp >= mlen) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_SPACES_PATH;
				end else if (data_byte == method_char(meth, mp)) begin
					role = ROLE_METHOD;
					mp_n = mp + 3'd1;
				end else begin
					err = 1'b1;
				end
			end
			S_SPACES_PATH: begin
				if (data_byte == CH_SP) begin
					role = ROLE_SPACE;
				end else if (data_byte == CH_SLASH) begin
					role = ROLE_PATH;
					fs   = 1'b1;
					st_n = S_PATH;
				end else begin
					err = 1'b1;
				end
			end
			S_PATH: begin
				if (data_byte == CH_SP) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_SPACES_VER;
				end else begin
					role = ROLE_PATH;
				end
			end
			S_SPACES_VER: begin
				if (data_byte == CH_SP) begin
					role = ROLE_SPACE;
				end else begin
					// first version letter: clear accumulators, match 'H'
					maj_n = 8'd0;
					min_n = 8'd0;
					mp_n  = 3'd0;
					st_n  = S_VER_WORD;
					if (data_byte == http_char(3'd0)) begin
						role = ROLE_VERSION;
						mp_n = 3'd1;
					end else begin
						err = 1'b1;
					end
				end
			end
			S_VER_WORD: begin
				if (mp < LEN_HTTP) begin
					if (data_byte == http_char(mp)) begin
						role = ROLE_VERSION;
						mp_n = mp + 3'd1;
					end else begin
						err = 1'b1;
					end
				end else if (data_byte == CH_SLASH) begin
					role = ROLE_VERSION;
					st_n = S_MAJOR;
				end else begin
					err = 1'b1;
				end
			end
			S_MAJOR: begin
				if (data_byte == CH_DOT) begin
					role = ROLE_VERSION;
					st_n = S_MINOR;
				end else if (is_digit(data_byte)) begin
					role  = ROLE_VERSION;
					maj_n = sat8(maj, data_byte);
				end else begin
					err = 1'b1;
				end
			end
			S_MINOR: begin
				if (is_digit(data_byte)) begin
					role  = ROLE_VERSION;
					min_n = sat8(mnr, data_byte);
				end else if (parse_mode) begin
					if (data_byte == CH_SP) begin
						role = ROLE_DELIM;
						fe   = 1'b1;
						st_n = S_SPACES_STATUS;
					end else begin
						err = 1'b1;
					end
				end else if (data_byte == CH_CR) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_FIN_REQ;
				end else begin
					err = 1'b1;
				end
			end
			S_FIN_REQ: begin
				if (data_byte == CH_LF) begin
					role = ROLE_DELIM;
					ev   = EV_REQ_DONE;
					st_n = S_HDR_START;
				end else begin
					err = 1'b1;
				end
			end
			S_SPACES_STATUS: begin
				if (data_byte == CH_SP) begin
					role = ROLE_SPACE;
				end else if (is_digit(data_byte)) begin
					role   = ROLE_STATUS;
					stat_n = sat16(stv, data_byte);
					st_n   = S_STATUS;
				end else begin
					err = 1'b1;
				end
			end
			S_STATUS: begin
				if (data_byte == CH_SP) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_SPACES_MSG;
				end else if (is_digit(data_byte)) begin
					role   = ROLE_STATUS;
					stat_n = sat16(stv, data_byte);
				end else begin
					err = 1'b1;
				end
			end
			S_SPACES_MSG: begin
				if (data_byte == CH_SP) begin
					role = ROLE_SPACE;
				end else if (data_byte == CH_CR) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_FIN_STATUS;
				end else begin
					role = ROLE_TEXT;
					fs   = 1'b1;
					st_n = S_MSG;
				end
			end
			S_MSG: begin
				if (data_byte == CH_CR) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_FIN_STATUS;
				end else begin
					role = ROLE_TEXT;
				end
			end
			S_FIN_STATUS: begin
				if (data_byte == CH_LF) begin
					role = ROLE_DELIM;
					ev   = EV_STAT_DONE;
					st_n = S_HDR_START;
				end else begin
					err = 1'b1;
				end
			end
			S_HDR_START: begin
				if (data_byte == CH_CR) begin
					role = ROLE_DELIM;
					st_n = S_HEAD_END;
				end else if (data_byte == CH_COLON) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_SPACES_VALUE;
				end else begin
					role = ROLE_NAME;
					fs   = 1'b1;
					st_n = S_HDR_NAME;
				end
			end
			S_HDR_NAME: begin
				if (data_byte == CH_COLON) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_SPACES_VALUE;
				end else begin
					role = ROLE_NAME;
				end
			end
			S_SPACES_VALUE: begin
				if (data_byte == CH_SP) begin
					role = ROLE_SPACE;
				end else if (data_byte == CH_CR) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_HDR_END;
				end else begin
					role = ROLE_VALUE;
					fs   = 1'b1;
					st_n = S_HDR_VALUE;
				end
			end
			S_HDR_VALUE: begin
				if (data_byte == CH_CR) begin
					role = ROLE_DELIM;
					fe   = 1'b1;
					st_n = S_HDR_END;
				end else begin
					role = ROLE_VALUE;
				end
			end
			S_HDR_END: begin
				if (data_byte == CH_LF) begin
					role = ROLE_DELIM;
					ev   = EV_HDR_DONE;
					st_n = S_HDR_START;
				end else begin
					err = 1'b1;
				end
			end
			S_HEAD_END: begin
				if (data_byte == CH_LF) begin
					role = ROLE_DELIM;
					ev   = EV_HEAD_DONE;
					st_n = S_PAST;
				end else begin
					err = 1'b1;
				end
			end
			S_PAST: begin
				role = ROLE_PAST;
			end
			default: begin
				// error state and unused codes stay in error
				err = 1'b1;
			end
		endcase

		if (err) begin
			st_n = S_ERROR;
			role = ROLE_PAST;
			fs   = 1'b0;
			fe   = 1'b0;
			ev   = EV_ERROR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_METHOD_START;
			mp_q    <= 3'd0;
			meth_q  <= METHOD_GET;
			maj_q   <= 8'd0;
			min_q   <= 8'd0;
			stat_q  <= 16'd0;
		end else if (step_en) begin
			state_q <= st_n;
			mp_q    <= mp_n;
			meth_q  <= meth_n;
			maj_q   <= maj_n;
			min_q   <= min_n;
			stat_q  <= stat_n;
		end
	end

	always_comb begin
		res.byte_role     = role;
		res.field_start   = fs;
		res.field_end     = fe;
		res.event_res     = ev;
		res.method_kind   = meth_n;
		res.version_major = maj_n;
		res.version_minor = min_n;
		res.status_value  = stat_n;
	end

	`HMHP_ASSERT_NEXT(a_error_sticky, step_en && !new_message && state_q == S_ERROR, state_q == S_ERROR, "error state left without a new message")
	`HMHP_ASSERT_NEXT(a_hold_when_idle, !step_en, $stable(state_q) && $stable(stat_q) && $stable(maj_q), "parser state moved without a beat")
	`HMHP_ASSERT_NOW(a_error_tag, res.event_res == EV_ERROR, res.byte_role == ROLE_PAST && !res.field_start && !res.field_end, "error beat carries a field tag")
	`HMHP_ASSERT_NOW(a_start_not_end, 1'b1, !(res.field_start && res.field_end), "byte both starts and ends a field")

endmodule

// ===== hdl/http_message_head_parser_core.sv =====
// ---------------------------------------------------------------------------
// http_message_head_parser_core
// Byte-stream HTTP/1.x message head parser: tags each byte with its role.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Beat carries
//  --------  ---------  ---------------------------------------------------
//  in_bus    sink       data_byte, new_message (restart before this byte)
//  out_bus   source     byte_role, field flags, event, method, version, status
//  APB       slave      parse_mode at byte address 0
//
//  One byte per cycle sustained while out_bus is ready; each beat is
//  registered at the input (stage 1), stepped through the parse state
//  machine and registered at the output (stage 2).
//  The parse state advances only when a stage-1 byte moves into the output
//  register, so stalls on out_bus hold everything and drop nothing.
//  arst_n clears the parser to the request start state and parse_mode to 0.
//  parse_mode picks the start state on new_message; S_MINOR reads it directly.
//
`include "http_message_head_parser_core_macros.svh"

module http_message_head_parser_core
	import hmhp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	hmhp_in_if.sink               in_bus,
	hmhp_out_if.source            out_bus,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic       parse_mode;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       newmsg_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    step_res;
	logic       advance;
	logic       in_ready;

	hmhp_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.parse_mode (parse_mode)
	);

	// advance the stage-1 byte whenever the output register is free or drains
	assign advance  = valid_s1 && (!valid_s2 || out_bus.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_bus.ready = in_ready;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_bus.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_bus.valid) begin
			byte_s1   <= in_bus.data_byte;
			newmsg_s1 <= in_bus.new_message;
		end
	end

	// parse step between stage 1 and the output register
	hmhp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.data_byte   (byte_s1),
		.new_message (newmsg_s1),
		.parse_mode  (parse_mode),
		.res         (step_res)
	);

	// stage 2: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_bus.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= step_res;
		end
	end

	assign out_bus.valid         = valid_s2;
	assign out_bus.byte_role     = res_s2.byte_role;
	assign out_bus.field_start   = res_s2.field_start;
	assign out_bus.field_end     = res_s2.field_end;
	assign out_bus.event_res     = res_s2.event_res;
	assign out_bus.method_kind   = res_s2.method_kind;
	assign out_bus.version_major = res_s2.version_major;
	assign out_bus.version_minor = res_s2.version_minor;
	assign out_bus.status_value  = res_s2.status_value;

	`HMHP_ASSERT_NOW(a_backpressure_full, !in_ready, valid_s1 && valid_s2, "input stalled with a free stage")
	`HMHP_ASSERT_NEXT(a_advance_fills, advance, valid_s2, "advanced beat missing from output register")

endmodule

// ===== tb/sv/http_message_head_parser_core_tb.sv =====
// ---------------------------------------------------------------------------
// http_message_head_parser_core_tb
// Self-checking bench for the HTTP message head parser. Feeds request and
// response heads, broken heads and raw noise one byte per beat. Every
// result beat is compared, field by field, with a cycle-free model of the
// parse state machine.
// ---------------------------------------------------------------------------
module http_message_head_parser_core_tb
	import hmhp_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [APB_ADDR_W-1:0] ADDR_PARSE_MODE = {REG_PARSE_MODE, 2'b00};

	// Model of the parser. It keeps its own parse state and accumulators, and
	// it queues one expected tag per accepted byte.
	class head_tag_scoreboard;
		logic        mode;
		logic [4:0]  st;
		logic [2:0]  pos;
		logic        meth;
		logic [7:0]  maj;
		logic [7:0]  mnr;
		logic [15:0] stat;
		result_t     expected_tags[$];
		int          errors;

		function new();
			mode = 1'b0;
			restart();
			errors = 0;
		endfunction

		function void restart();
			st = mode ? S_SPACES_VER : S_METHOD_START;
			pos = '0;
			meth = METHOD_GET;
			maj = '0;
			mnr = '0;
			stat = '0;
		endfunction

		function logic is_dec(logic [7:0] c);
			return (c >= CH_ZERO) && (c <= CH_NINE);
		endfunction

		function logic [7:0] acc8(logic [7:0] a, logic [7:0] c);
			int v;
			v = int'(a) * 10 + int'(c) - int'(CH_ZERO);
			return (v > 255) ? 8'hFF : v[7:0];
		endfunction

		function logic [15:0] acc16(logic [15:0] a, logic [7:0] c);
			int v;
			v = int'(a) * 10 + int'(c) - int'(CH_ZERO);
			return (v > 65535) ? 16'hFFFF : v[15:0];
		endfunction

		function void note_byte(logic [7:0] c, logic fresh);
			result_t r;
			logic    err;
			string   word;
			string   http_word;
			int      wlen;
			r = '0;
			r.byte_role = ROLE_PAST;
			err = 1'b0;
			http_word = "HTTP";
			if (fresh)
				restart();
			// the first non-space byte of the version both leaves the space run
			// and is checked as the first letter of the version word
			if (st == S_SPACES_VER) begin
				if (c == CH_SP) begin
					r.byte_role = ROLE_SPACE;
				end else begin
					maj = '0;
					mnr = '0;
					pos = '0;
					st = S_VER_WORD;
				end
			end
			case (st)
				S_METHOD_START: begin
					if (c == CH_G || c == CH_P) begin
						meth = (c == CH_P) ? METHOD_POST : METHOD_GET;
						pos = 3'd1;
						st = S_METHOD;
						r.byte_role = ROLE_METHOD;
					end else begin
						err = 1'b1;
					end
				end
				S_METHOD: begin
					if (meth == METHOD_POST)
						word = "POST";
					else
						word = "GET";
					wlen = int'((meth == METHOD_POST) ? LEN_POST : LEN_GET);
					if (pos >= wlen) begin
						// whole word matched: any byte closes it
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_SPACES_PATH;
					end else if (c == word[pos]) begin
						r.byte_role = ROLE_METHOD;
						pos = pos + 3'd1;
					end else begin
						err = 1'b1;
					end
				end
				S_SPACES_PATH: begin
					if (c == CH_SP) begin
						r.byte_role = ROLE_SPACE;
					end else if (c == CH_SLASH) begin
						r.byte_role = ROLE_PATH;
						r.field_start = 1'b1;
						st = S_PATH;
					end else begin
						err = 1'b1;
					end
				end
				S_PATH: begin
					if (c == CH_SP) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_SPACES_VER;
					end else begin
						r.byte_role = ROLE_PATH;
					end
				end
				S_SPACES_VER: ;
				S_VER_WORD: begin
					if (pos < LEN_HTTP) begin
						if (c == http_word[pos]) begin
							r.byte_role = ROLE_VERSION;
							pos = pos + 3'd1;
						end else begin
							err = 1'b1;
						end
					end else if (c == CH_SLASH) begin
						r.byte_role = ROLE_VERSION;
						st = S_MAJOR;
					end else begin
						err = 1'b1;
					end
				end
				S_MAJOR: begin
					if (c == CH_DOT) begin
						r.byte_role = ROLE_VERSION;
						st = S_MINOR;
					end else if (is_dec(c)) begin
						r.byte_role = ROLE_VERSION;
						maj = acc8(maj, c);
					end else begin
						err = 1'b1;
					end
				end
				S_MINOR: begin
					if (is_dec(c)) begin
						r.byte_role = ROLE_VERSION;
						mnr = acc8(mnr, c);
					end else if (mode) begin
						if (c == CH_SP) begin
							r.byte_role = ROLE_DELIM;
							r.field_end = 1'b1;
							st = S_SPACES_STATUS;
						end else begin
							err = 1'b1;
						end
					end else if (c == CH_CR) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_FIN_REQ;
					end else begin
						err = 1'b1;
					end
				end
				S_FIN_REQ: begin
					if (c == CH_LF) begin
						r.byte_role = ROLE_DELIM;
						r.event_res = EV_REQ_DONE;
						st = S_HDR_START;
					end else begin
						err = 1'b1;
					end
				end
				S_SPACES_STATUS: begin
					if (c == CH_SP) begin
						r.byte_role = ROLE_SPACE;
					end else if (is_dec(c)) begin
						r.byte_role = ROLE_STATUS;
						stat = acc16(stat, c);
						st = S_STATUS;
					end else begin
						err = 1'b1;
					end
				end
				S_STATUS: begin
					if (c == CH_SP) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_SPACES_MSG;
					end else if (is_dec(c)) begin
						r.byte_role = ROLE_STATUS;
						stat = acc16(stat, c);
					end else begin
						err = 1'b1;
					end
				end
				S_SPACES_MSG: begin
					if (c == CH_SP) begin
						r.byte_role = ROLE_SPACE;
					end else if (c == CH_CR) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_FIN_STATUS;
					end else begin
						r.byte_role = ROLE_TEXT;
						r.field_start = 1'b1;
						st = S_MSG;
					end
				end
				S_MSG: begin
					if (c == CH_CR) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_FIN_STATUS;
					end else begin
						r.byte_role = ROLE_TEXT;
					end
				end
				S_FIN_STATUS: begin
					if (c == CH_LF) begin
						r.byte_role = ROLE_DELIM;
						r.event_res = EV_STAT_DONE;
						st = S_HDR_START;
					end else begin
						err = 1'b1;
					end
				end
				S_HDR_START: begin
					if (c == CH_CR) begin
						r.byte_role = ROLE_DELIM;
						st = S_HEAD_END;
					end else if (c == CH_COLON) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_SPACES_VALUE;
					end else begin
						r.byte_role = ROLE_NAME;
						r.field_start = 1'b1;
						st = S_HDR_NAME;
					end
				end
				S_HDR_NAME: begin
					if (c == CH_COLON) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_SPACES_VALUE;
					end else begin
						r.byte_role = ROLE_NAME;
					end
				end
				S_SPACES_VALUE: begin
					if (c == CH_SP) begin
						r.byte_role = ROLE_SPACE;
					end else if (c == CH_CR) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_HDR_END;
					end else begin
						r.byte_role = ROLE_VALUE;
						r.field_start = 1'b1;
						st = S_HDR_VALUE;
					end
				end
				S_HDR_VALUE: begin
					if (c == CH_CR) begin
						r.byte_role = ROLE_DELIM;
						r.field_end = 1'b1;
						st = S_HDR_END;
					end else begin
						r.byte_role = ROLE_VALUE;
					end
				end
				S_HDR_END: begin
					if (c == CH_LF) begin
						r.byte_role = ROLE_DELIM;
						r.event_res = EV_HDR_DONE;
						st = S_HDR_START;
					end else begin
						err = 1'b1;
					end
				end
				S_HEAD_END: begin
					if (c == CH_LF) begin
						r.byte_role = ROLE_DELIM;
						r.event_res = EV_HEAD_DONE;
						st = S_PAST;
					end else begin
						err = 1'b1;
					end
				end
				S_PAST: r.byte_role = ROLE_PAST;
				default: err = 1'b1;
			endcase
			if (err) begin
				st = S_ERROR;
				r.byte_role = ROLE_PAST;
				r.field_start = 1'b0;
				r.field_end = 1'b0;
				r.event_res = EV_ERROR;
			end
			r.method_kind = meth;
			r.version_major = maj;
			r.version_minor = mnr;
			r.status_value = stat;
			expected_tags.push_back(r);
		endfunction

		function void cmp(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_tags.size() == 0) begin
				$error("result beat with no byte outstanding");
				errors++;
				return;
			end
			want = expected_tags.pop_front();
			cmp("byte_role", want.byte_role, got.byte_role);
			cmp("field_start", want.field_start, got.field_start);
			cmp("field_end", want.field_end, got.field_end);
			cmp("event_res", want.event_res, got.event_res);
			cmp("method_kind", want.method_kind, got.method_kind);
			cmp("version_major", want.version_major, got.version_major);
			cmp("version_minor", want.version_minor, got.version_minor);
			cmp("status_value", want.status_value, got.status_value);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	hmhp_in_if  in_ch();
	hmhp_out_if out_ch();

	head_tag_scoreboard sb = new();

	// Stimulus bookkeeping
	logic [7:0] msg_bytes[$];   // head under construction
	bit         idle_on;        // allow gaps and stalls for the current head
	int         stall_left;
	int         sent_count;

	http_message_head_parser_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_bus  (in_ch),
		.out_bus (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard stop in case the block hangs: far beyond the slowest clean run.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// Receiver side: stall in bursts while idling is allowed.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready = 1'b0;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_ch.ready = 1'b0;
			stall_left = $urandom_range(1, 5) - 1;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// Monitor: note the accepted byte first so that a result leaving on the
	// same edge would still find its expectation.
	always @(posedge clk) begin
		result_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.data_byte, in_ch.new_message);
			if (out_ch.valid && out_ch.ready) begin
				got.byte_role = out_ch.byte_role;
				got.field_start = out_ch.field_start;
				got.field_end = out_ch.field_end;
				got.event_res = out_ch.event_res;
				got.method_kind = out_ch.method_kind;
				got.version_major = out_ch.version_major;
				got.version_minor = out_ch.version_minor;
				got.status_value = out_ch.status_value;
				sb.check_result(got);
			end
		end
	end

	// Drive one byte; entered and left at a falling edge. Valid stays high on
	// exit so that back-to-back beats need no reassignment.
	task automatic send_byte(input logic [7:0] c, input logic fresh);
		int gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data_byte = c;
		in_ch.new_message = fresh;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		sent_count++;
	endtask

	// Send the queued head, restarting the parser on its first byte.
	task automatic send_head();
		foreach (msg_bytes[i])
			send_byte(msg_bytes[i], i == 0);
		msg_bytes.delete();
	endtask

	// Hold the sender until every outstanding result has come back.
	task automatic drain();
		in_ch.valid = 1'b0;
		while (sb.expected_tags.size() != 0) @(negedge clk);
	endtask

	// Write parse_mode while idle, then read it back.
	task automatic change_mode(input logic m);
		drain();
		repeat (4) @(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		paddr = ADDR_PARSE_MODE;
		pwdata = {{(APB_DATA_W-1){1'b0}}, m};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.mode = m;
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== m) begin
			$error("parse_mode: expected %0d, got %0d", m, prdata[0]);
			sb.errors++;
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	function automatic logic [7:0] pick_byte(input logic [7:0] no_a, input logic [7:0] no_b);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == no_a || b == no_b);
		return b;
	endfunction

	function automatic void put_text(input string s);
		foreach (s[i]) msg_bytes.push_back(s[i]);
	endfunction

	function automatic void put_spaces(input int n);
		repeat (n) msg_bytes.push_back(CH_SP);
	endfunction

	function automatic void put_digits(input int n);
		repeat (n) msg_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	// Mostly short numbers; now and then long enough to saturate.
	function automatic int num_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
	endfunction

	function automatic void put_version();
		put_text("HTTP/");
		put_digits(num_len());
		msg_bytes.push_back(CH_DOT);
		put_digits(num_len());
	endfunction

	// Header lines, the empty line, and a few bytes past the head.
	function automatic void put_headers();
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 9) != 0) begin
				msg_bytes.push_back(pick_byte(CH_CR, CH_COLON));
				repeat ($urandom_range(0, 5)) msg_bytes.push_back(pick_byte(CH_COLON, CH_COLON));
			end
			msg_bytes.push_back(CH_COLON);
			put_spaces($urandom_range(0, 2));
			if ($urandom_range(0, 5) != 0) begin
				msg_bytes.push_back(pick_byte(CH_CR, CH_SP));
				repeat ($urandom_range(0, 7)) msg_bytes.push_back(pick_byte(CH_CR, CH_CR));
			end
			msg_bytes.push_back(CH_CR);
			msg_bytes.push_back(CH_LF);
		end
		msg_bytes.push_back(CH_CR);
		msg_bytes.push_back(CH_LF);
		repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_request();
		if ($urandom_range(0, 1))
			put_text("POST");
		else
			put_text("GET");
		// the byte after the method closes it whatever it is
		msg_bytes.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : CH_SP);
		put_spaces($urandom_range(0, 2));
		msg_bytes.push_back(CH_SLASH);
		repeat ($urandom_range(0, 8)) msg_bytes.push_back(pick_byte(CH_SP, CH_SP));
		msg_bytes.push_back(CH_SP);
		put_spaces($urandom_range(0, 2));
		put_version();
		msg_bytes.push_back(CH_CR);
		msg_bytes.push_back(CH_LF);
		put_headers();
	endfunction

	function automatic void put_response();
		put_spaces($urandom_range(0, 2));
		put_version();
		msg_bytes.push_back(CH_SP);
		put_spaces($urandom_range(0, 2));
		put_digits(($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3));
		msg_bytes.push_back(CH_SP);
		put_spaces($urandom_range(0, 2));
		if ($urandom_range(0, 4) != 0) begin
			msg_bytes.push_back(pick_byte(CH_SP, CH_CR));
			repeat ($urandom_range(0, 10)) msg_bytes.push_back(pick_byte(CH_CR, CH_CR));
		end
		msg_bytes.push_back(CH_CR);
		msg_bytes.push_back(CH_LF);
		put_headers();
	endfunction

	// One random phase: mostly well-formed heads of the current mode, mixed with
	// corrupted or cut heads, heads of the other mode, and raw noise.
	task automatic run_phase(input int quota, input logic mode, input bit allow_idle,
			input bit pause_mid);
		int  first;
		int  kind;
		int  cut;
		int  p;
		bit  paused;
		first = sent_count;
		paused = 0;
		while (sent_count - first < quota) begin
			kind = $urandom_range(0, 99);
			idle_on = allow_idle && ($urandom_range(0, 3) != 0);
			if (kind < 88) begin
				if ((kind >= 80) ? !mode : mode)
					put_response();
				else
					put_request();
				if (kind >= 64 && kind < 72) begin
					p = $urandom_range(0, msg_bytes.size() - 1);
					msg_bytes[p] = 8'($urandom_range(0, 255));
				end else if (kind >= 72 && kind < 80) begin
					// cut short: the next head restarts the parser mid-line
					cut = $urandom_range(1, msg_bytes.size());
					while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
				end
				send_head();
			end else begin
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
			end
			if (pause_mid && !paused && sent_count - first >= quota / 2) begin
				drain();
				paused = 1;
			end
		end
	endtask

	initial begin
		logic phase_modes[6];
		phase_modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.new_message = 1'b0;
		out_ch.ready = 1'b1;
		idle_on = 0;
		stall_left = 0;
		sent_count = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Request mode: POST closed by an arbitrary byte, a saturating major,
		// an empty header name with an empty value, the empty line, and a
		// byte past the head.
		change_mode(1'b0);
		put_text("POSTX/ HTTP/999.0\r\n:\r\n\r\n");
		msg_bytes.push_back(8'hFF);
		send_head();
		// Method mismatch, then a byte that stays in error.
		put_text("GEX?");
		send_head();

		// Response mode: saturating status with empty status text.
		change_mode(1'b1);
		put_text(" HTTP/1.1 70000 \r\n\r\n");
		send_head();
		// Version letter mismatch.
		put_text("HTTQ");
		send_head();

		// Random phases; the last one runs without gaps or stalls.
		foreach (phase_modes[i]) begin
			change_mode(phase_modes[i]);
			run_phase(290, phase_modes[i], i != 5, i == 2);
		end
		idle_on = 0;

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.expected_tags.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
